// ===== rtl/grg_pkg.sv =====
// grg_pkg: widths, constants, the case code and the side_t stage struct for the Givens rotation generator.
// No dependencies.
`timescale 1ns / 1ps
package grg_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned RootW = 32;
  localparam int unsigned QW = 31;            // quotient bits, up to 2^30 inclusive
  localparam logic [QW-1:0] OneQ30 = QW'(32'h4000_0000);

  typedef logic [DataW-1:0] word_t;

  // special case code travelling with each word
  typedef enum logic [1:0] {
    CASE_GEN   = 2'd0,
    CASE_ZERO  = 2'd1,
    CASE_A     = 2'd2,
    CASE_B     = 2'd3
  } case_e;

  typedef struct packed {
    logic        a_neg;
    logic        b_neg;
    logic [32:0] a_mag;
    logic [32:0] b_mag;
    case_e       kind;
  } side_t;
endpackage

// ===== rtl/grg_stream_if.sv =====
// grg_stream_if: valid/ready channel carrying one payload word.
// Depends on nothing but the payload type parameter.
`timescale 1ns / 1ps
interface grg_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/grg_in_t.sv =====
// grg_square: square-and-sum front stage.
// Depends on grg_pkg.
`timescale 1ns / 1ps
module grg_square (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  grg_pkg::word_t       a_i,
  input  grg_pkg::word_t       b_i,
  output logic                 vld_o,
  output logic [63:0]          sum_o,
  output grg_pkg::side_t       side_o
);
  import grg_pkg::*;
  logic [32:0] a_mag, b_mag;
  logic        a_neg, b_neg;
  logic [32:0] am_q, bm_q;
  logic        an_q, bn_q, v1_q;
  logic [63:0] a2_q, b2_q;
  side_t       s2_q;
  logic        v2_q;
  case_e       kind;

  assign a_neg = a_i[31];
  assign b_neg = b_i[31];
  assign a_mag = a_neg ? 33'(-{1'b1, a_i}) : {1'b0, a_i};
  assign b_mag = b_neg ? 33'(-{1'b1, b_i}) : {1'b0, b_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      am_q <= a_mag;
      bm_q <= b_mag;
      an_q <= a_neg;
      bn_q <= b_neg;
      // magnitude up to 2^31: square of low bits, top case exact as 2^62
      a2_q <= am_q[32] ? 64'h4000_0000_0000_0000 : {32'd0, am_q[31:0]} * {32'd0, am_q[31:0]};
      b2_q <= bm_q[32] ? 64'h4000_0000_0000_0000 : {32'd0, bm_q[31:0]} * {32'd0, bm_q[31:0]};
      s2_q <= '{a_neg: an_q, b_neg: bn_q, a_mag: am_q, b_mag: bm_q, kind: kind};
    end
  end

  always_comb begin
    if (am_q == '0 && bm_q == '0) kind = CASE_ZERO;
    else if (bm_q == '0)         kind = CASE_A;
    else if (am_q == '0)         kind = CASE_B;
    else                         kind = CASE_GEN;
  end

  assign vld_o  = v2_q;
  assign sum_o  = a2_q + b2_q;
  assign side_o = s2_q;
endmodule

// ===== rtl/grg_sqrt.sv =====
// grg_sqrt: pipelined restoring integer square root, one root bit per stage.
// Depends on grg_pkg.
`timescale 1ns / 1ps
module grg_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [63:0]    sum_i,
  input  grg_pkg::side_t side_i,
  output logic           vld_o,
  output logic [31:0]    root_o,
  output grg_pkg::side_t side_o
);
  import grg_pkg::*;
  localparam int unsigned N = RootW;
  logic [63:0] x_q [N+1];
  logic [33:0] r_q [N+1];   // partial remainder
  logic [31:0] q_q [N+1];
  side_t       sd_q [N+1];
  logic [N:0]  v_q;

  always_comb begin
    x_q[0]  = sum_i;
    r_q[0]  = '0;
    q_q[0]  = '0;
    sd_q[0] = side_i;
    v_q[0]  = vld_i;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [33:0] rt, tr;
    logic        ge;
    assign rt = {r_q[i][31:0], x_q[i][63-2*i -: 2]};
    assign tr = {q_q[i], 2'b01};
    assign ge = rt >= tr;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i+1] <= 1'b0;
      else if (en_i) v_q[i+1] <= v_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]  <= x_q[i];
        r_q[i+1]  <= ge ? rt - tr : rt;
        q_q[i+1]  <= {q_q[i][30:0], ge};
        sd_q[i+1] <= sd_q[i];
      end
    end
  end

  assign vld_o  = v_q[N];
  assign root_o = q_q[N];
  assign side_o = sd_q[N];
endmodule

// ===== rtl/grg_divide.sv =====
// grg_divide: two pipelined restoring dividers giving rounded Q2.30 ratios.
// Depends on grg_pkg.
`timescale 1ns / 1ps
module grg_divide (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [31:0]    root_i,
  input  grg_pkg::side_t side_i,
  output logic           vld_o,
  output grg_pkg::word_t cos_o,
  output grg_pkg::word_t sin_o,
  output grg_pkg::word_t mag_o
);
  import grg_pkg::*;
  // numerator = |x|*2^30 + floor(rho/2), 64 bits; quotient <= 2^30 so 31 bits
  localparam int unsigned N = QW;
  localparam int unsigned TopB = 63;
  logic [63:0] na_q [N+1], nb_q [N+1];
  logic [32:0] ra_q [N+1], rb_q [N+1];
  logic [30:0] qa_q [N+1], qb_q [N+1];
  logic [31:0] d_q [N+1];
  side_t       sd_q [N+1];
  logic [N:0]  v_q;

  always_comb begin
    na_q[0] = ({31'd0, side_i.a_mag} << 30) + {33'd0, root_i[31:1]};
    nb_q[0] = ({31'd0, side_i.b_mag} << 30) + {33'd0, root_i[31:1]};
    // quotient < 2^31: upper 33 bits of numerator are below divisor, so start there
    ra_q[0] = na_q[0][TopB:31];
    rb_q[0] = nb_q[0][TopB:31];
    qa_q[0] = '0;
    qb_q[0] = '0;
    d_q[0]  = root_i;
    sd_q[0] = side_i;
    v_q[0]  = vld_i;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [33:0] ta, tb;
    logic        ga, gb;
    assign ta = {ra_q[i], na_q[i][30-i]};
    assign tb = {rb_q[i], nb_q[i][30-i]};
    assign ga = ta >= {2'b00, d_q[i]};
    assign gb = tb >= {2'b00, d_q[i]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i+1] <= 1'b0;
      else if (en_i) v_q[i+1] <= v_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        na_q[i+1] <= na_q[i];
        nb_q[i+1] <= nb_q[i];
        ra_q[i+1] <= 33'(ga ? ta - {2'b00, d_q[i]} : ta);
        rb_q[i+1] <= 33'(gb ? tb - {2'b00, d_q[i]} : tb);
        qa_q[i+1] <= {qa_q[i][29:0], ga};
        qb_q[i+1] <= {qb_q[i][29:0], gb};
        d_q[i+1]  <= d_q[i];
        sd_q[i+1] <= sd_q[i];
      end
    end
  end

  side_t       sd;
  logic [30:0] ca, cb;
  logic [31:0] c_mag, s_mag, m;
  assign sd = sd_q[N];
  assign ca = (qa_q[N] > OneQ30) ? OneQ30 : qa_q[N];
  assign cb = (qb_q[N] > OneQ30) ? OneQ30 : qb_q[N];

  always_comb begin
    case (sd.kind)
      CASE_ZERO: begin c_mag = '0; s_mag = '0; m = '0; end
      CASE_A:    begin c_mag = {1'b0, OneQ30}; s_mag = '0; m = sd.a_mag[31:0]; end
      CASE_B:    begin c_mag = '0; s_mag = {1'b0, OneQ30}; m = sd.b_mag[31:0]; end
      default:   begin c_mag = {1'b0, ca}; s_mag = {1'b0, cb}; m = d_q[N]; end
    endcase
  end

  logic [31:0] mag_fix;
  assign mag_fix = (sd.kind == CASE_A && sd.a_mag[32]) ||
                   (sd.kind == CASE_B && sd.b_mag[32]) ? 32'h8000_0000 : m;
  assign vld_o = v_q[N];
  assign cos_o = sd.a_neg ? -c_mag : c_mag;
  assign sin_o = sd.b_neg ? -s_mag : s_mag;
  assign mag_o = mag_fix;
endmodule

// ===== rtl/givens_rotation_generator_top.sv =====
// Givens rotation generator: top level with output register.
// Depends on grg_pkg, grg_stream_if, grg_square, grg_sqrt, grg_divide.
`timescale 1ns / 1ps
// Usage
//  in_i  : sink word {a_value, b_value}, signed Q16.16 each.
//  out_o : source word {cosine, sine} signed Q2.30 and magnitude unsigned Q16.16.
//  Pipeline: square/sum stages, root stages (one root bit per stage),
//  divide stages (one quotient bit per stage), then 1 output register.
//  Throughput: one word per cycle while the output is not stalled; set by the
//  bit-per-stage root and divider pipelines, which hold one word in each stage.
//  The whole pipeline advances while the output register is free or being
//  taken; a stalled receiver freezes every stage, so nothing is lost or repeated.
//  in_i.ready is high whenever the output register is empty or read this cycle.
//  Reset (rst_ni low, asynchronous) clears all valid bits; payload is left.
//  b zero: cosine is sign(a), sine zero; a zero: the reverse; both zero: all zero.
//  The most negative input is taken at its exact magnitude 2^31.
module givens_rotation_generator_top (
  input  logic clk_i,
  input  logic rst_ni,
  grg_stream_if.sink   in_i,
  grg_stream_if.source out_o
);
  import grg_pkg::*;

  logic        en;
  logic        sq_v, rt_v, dv_v;
  logic [63:0] sum;
  side_t       sd1, sd2;
  logic [31:0] root;
  word_t       cs, sn, mg;
  logic        o_v_q;
  word_t       o_c_q, o_s_q, o_m_q;

  // pipeline moves unless a result waits in the output register unread
  assign en = !o_v_q || out_o.ready;
  assign in_i.ready = en;

  grg_square u_sq (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_i.valid),
    .a_i(in_i.data.a_value), .b_i(in_i.data.b_value),
    .vld_o(sq_v), .sum_o(sum), .side_o(sd1)
  );

  grg_sqrt u_rt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(sq_v), .sum_i(sum), .side_i(sd1),
    .vld_o(rt_v), .root_o(root), .side_o(sd2)
  );

  grg_divide u_dv (
    .clk_i, .rst_ni, .en_i(en), .vld_i(rt_v), .root_i(root), .side_i(sd2),
    .vld_o(dv_v), .cos_o(cs), .sin_o(sn), .mag_o(mg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_v_q <= 1'b0;
    else if (en) o_v_q <= dv_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_c_q <= cs;
      o_s_q <= sn;
      o_m_q <= mg;
    end
  end

  assign out_o.valid          = o_v_q;
  assign out_o.data.cosine    = o_c_q;
  assign out_o.data.sine      = o_s_q;
  assign out_o.data.magnitude = o_m_q;

`ifndef SYNTHESIS
  // a held result must not be overwritten; checked on the magnitude field
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data.magnitude))
    else $error("output word changed while stalled");
  // cosine never beyond one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ($signed(out_o.data.cosine) <= 32'sh4000_0000 &&
                     $signed(out_o.data.cosine) >= -32'sh4000_0000))
    else $error("cosine out of range");
  // input ready follows output stall
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken during stall");
`endif
endmodule
